FILE: rtl/core/agc_pkg.sv
// agc_pkg: shared types and constants for the anagram group classifier
// word layouts, action codes, cell control bundle and parameter defaults
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package agc_pkg;

	// parameter defaults
	localparam int MAX_GROUPS_DEF = 64;
	localparam int COUNT_BITS_DEF = 8;
	localparam int ALPHABET_DEF   = 26;

	// fixed field widths
	localparam int ACTION_W = 2;
	localparam int LETTER_W = 5;
	localparam int GROUP_W  = 6;
	// wide enough to compare a letter code with any cell position up to 64
	localparam int CELL_POS_W = 7;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_LETTER = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_EOS    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

	// input word
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [LETTER_W-1:0] letter;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [GROUP_W-1:0] group_number;
		logic               new_group;
		logic               table_full;
	} out_word_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic                inc;
		logic                clr;
		logic                rd;
		logic                wr;
		logic [LETTER_W-1:0] letter;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/anagram_group_classifier.sv
// anagram_group_classifier: top level, sequencer and chain of letter cells
// groups strings by letter histogram; depends on agc_pkg and agc_cell
//
// Usage: words enter on item (action, letter) under item_valid/item_ready.
// A letter word bumps the count of its letter (saturating at
// 2^COUNT_BITS - 1, codes of ALPHABET or more are dropped); a clear word
// empties the group table. Neither gives a result.
// An end-of-string word starts a scan of the stored signatures: every cell
// reads its column of group k from its own memory and the per-letter
// compares are ANDed down the chain. One group is read per cycle and each
// read is registered in the cell, so an end-of-string word holds the input
// until a read of a stored group matches, or until every stored group has
// been read and missed; with an empty table no group is read.
// The result word (group_number, new_group, table_full) is loaded at the
// edge that frees the input, sits in an output register on result_valid
// and stays there until result_ready; letters and clears are still
// accepted while it waits, but the next end-of-string word cannot finish
// until the register is free. Reset clears the histogram, the group count
// and the output register; signature memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module anagram_group_classifier #(
	parameter int MAX_GROUPS = agc_pkg::MAX_GROUPS_DEF,
	parameter int COUNT_BITS = agc_pkg::COUNT_BITS_DEF,
	parameter int ALPHABET   = agc_pkg::ALPHABET_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  wire agc_pkg::in_word_t item,
	output logic                result_valid,
	input  wire                 result_ready,
	output agc_pkg::out_word_t  result
);

	localparam int IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int CNT_W = $clog2(MAX_GROUPS + 1);
	localparam logic [CNT_W-1:0] GROUPS_LIM = CNT_W'(MAX_GROUPS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    grp_cnt_q;
	logic [CNT_W-1:0]    scan_q;
	logic                rd_valid_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [IDX_W-1:0]    res_grp_q;
	logic                res_new_q;
	logic                res_full_q;
	logic                out_valid_q;
	agc_pkg::out_word_t  out_q;

	agc_pkg::cell_ctl_t  ctl;
	logic [ALPHABET:0]   match_chain;
	logic                accept;
	logic                issue;
	logic                hit;
	logic                miss;
	logic                out_free;
	logic                commit;
	logic [IDX_W+agc_pkg::GROUP_W-1:0] grp_wide;

	// handshake
	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_free     = !out_valid_q || result_ready;

	// scan control
	assign issue  = (state_q == ST_SCAN) && (scan_q < grp_cnt_q);
	assign hit    = (state_q == ST_SCAN) && rd_valid_s1 && match_chain[ALPHABET];
	assign miss   = (state_q == ST_SCAN) && !issue && !rd_valid_s1;
	assign commit = (state_q == ST_DONE) && out_free;

	// cell control bundle
	always_comb begin
		ctl.inc    = accept && (item.action == agc_pkg::ACT_LETTER);
		ctl.clr    = commit;
		ctl.rd     = issue;
		ctl.wr     = commit && res_new_q;
		ctl.letter = item.letter;
	end

	// row of letter cells
	assign match_chain[0] = 1'b1;
	for (genvar i = 0; i < ALPHABET; i++) begin : g_cell
		agc_cell #(
			.MAX_GROUPS (MAX_GROUPS),
			.COUNT_BITS (COUNT_BITS),
			.CELL_IDX   (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.rd_addr   (scan_q[IDX_W-1:0]),
			.wr_addr   (res_grp_q),
			.match_in  (match_chain[i]),
			.match_out (match_chain[i+1])
		);
	end

	// sequencer and group count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grp_cnt_q   <= '0;
			scan_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (item.action == agc_pkg::ACT_CLEAR)) begin
						grp_cnt_q <= '0;
					end
					if (accept && (item.action == agc_pkg::ACT_EOS)) begin
						scan_q      <= '0;
						rd_valid_s1 <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_valid_s1 <= issue;
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit || miss) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						if (res_new_q) begin
							grp_cnt_q <= grp_cnt_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan pipeline tag and decision
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[IDX_W-1:0];
		if (hit) begin
			res_grp_q  <= rd_idx_s1;
			res_new_q  <= 1'b0;
			res_full_q <= 1'b0;
		end else if (miss) begin
			if (grp_cnt_q < GROUPS_LIM) begin
				res_grp_q  <= grp_cnt_q[IDX_W-1:0];
				res_new_q  <= 1'b1;
				res_full_q <= 1'b0;
			end else begin
				res_grp_q  <= '0;
				res_new_q  <= 1'b0;
				res_full_q <= 1'b1;
			end
		end
	end

	// group number as the low bits of the index
	assign grp_wide = (IDX_W + agc_pkg::GROUP_W)'(res_grp_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.group_number <= grp_wide[agc_pkg::GROUP_W-1:0];
			out_q.new_group    <= res_new_q;
			out_q.table_full   <= res_full_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/agc_cell.sv
// agc_cell: one letter position of the classifier chain
// holds the running count of its letter and that letter's column of the
// signature table; depends on agc_pkg
`timescale 1ns / 1ps
`default_nettype none

module agc_cell #(
	parameter int MAX_GROUPS = agc_pkg::MAX_GROUPS_DEF,
	parameter int COUNT_BITS = agc_pkg::COUNT_BITS_DEF,
	parameter int CELL_IDX   = 0,
	localparam int IDX_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire agc_pkg::cell_ctl_t ctl,
	input  wire  [IDX_W-1:0]      rd_addr,
	input  wire  [IDX_W-1:0]      wr_addr,
	input  wire                   match_in,
	output logic                  match_out
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [agc_pkg::CELL_POS_W-1:0] MY_POS = agc_pkg::CELL_POS_W'(CELL_IDX);

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] column_mem [MAX_GROUPS];
	logic [COUNT_BITS-1:0] rd_data_q;
	logic                  hit_letter;

	// this cell's letter arrived
	assign hit_letter = ({{(agc_pkg::CELL_POS_W - agc_pkg::LETTER_W){1'b0}}, ctl.letter}
		== MY_POS);

	// saturating letter count, cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clr) begin
			count_q <= '0;
		end else if (ctl.inc && hit_letter && (count_q != COUNT_MAX)) begin
			count_q <= count_q + 1'b1;
		end
	end

	// signature column, one entry per group
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			column_mem[wr_addr] <= count_q;
		end
		if (ctl.rd) begin
			rd_data_q <= column_mem[rd_addr];
		end
	end

	// pass the match along the chain
	assign match_out = match_in && (rd_data_q == count_q);

endmodule

`default_nettype wire
